// ===== rtl/ewma_ad_pkg.sv =====
// ewma_ad_pkg: shared widths, register map, microcode control word and program ROM
// for the EWMA anomaly detector. No dependencies; compile first.
package ewma_ad_pkg;

	// fixed widths
	localparam int VAR_W    = 48;
	localparam int REG_W    = 16;
	localparam int COUNT_W  = 17;
	localparam int DIG_BITS = 16;

	localparam logic [VAR_W-1:0] VAR_MAX = '1;

	// register map, index = byte address / 4
	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_ALPHA  = 2'd0;
	localparam reg_idx_t REG_K      = 2'd1;
	localparam reg_idx_t REG_WARMUP = 2'd2;

	localparam logic [REG_W-1:0] ALPHA_RESET  = 16'd6554;
	localparam logic [REG_W-1:0] K_RESET      = 16'd768;
	localparam logic [REG_W-1:0] WARMUP_RESET = 16'd10;

	// sequencer step address
	typedef logic [3:0] step_t;
	localparam step_t STEP_FIRST = 4'd0;
	localparam step_t STEP_FIN   = 4'd15;

	// datapath action of one step
	typedef enum logic [3:0] {
		ACT_PREP,
		ACT_MAC,
		ACT_K2,
		ACT_SQ,
		ACT_TEST,
		ACT_INCR,
		ACT_MEAN,
		ACT_T,
		ACT_SUM,
		ACT_VAR,
		ACT_FIN
	} act_t;

	// multiplier operand selects
	typedef enum logic [1:0] {SA_K, SA_MAG, SA_VAR} sel_a_t;
	typedef enum logic [2:0] {SB_K, SB_MAG, SB_K2, SB_ALPHA, SB_INCR, SB_OMA} sel_b_t;

	// number of 16-bit digits of operand b
	typedef enum logic [1:0] {ND_ONE, ND_TWO, ND_MAG} nd_t;

	// sequencing condition
	typedef enum logic [1:0] {C_NEXT, C_SEED, C_MUL, C_OUT} cond_t;

	typedef struct packed {
		act_t   act;
		sel_a_t sel_a;
		sel_b_t sel_b;
		nd_t    nd;
		cond_t  cond;
		step_t  target;
	} ctrl_t;

	// microcode program: test, mean update, variance update
	function automatic ctrl_t ctrl_word(input step_t step);
		ctrl_t w;
		unique case (step)
			4'd0:  w = ctrl_t'{ACT_PREP, SA_K,   SB_K,     ND_ONE, C_SEED, STEP_FIN};
			4'd1:  w = ctrl_t'{ACT_MAC,  SA_K,   SB_K,     ND_ONE, C_MUL,  STEP_FIRST};
			4'd2:  w = ctrl_t'{ACT_K2,   SA_K,   SB_K,     ND_ONE, C_NEXT, STEP_FIRST};
			4'd3:  w = ctrl_t'{ACT_MAC,  SA_MAG, SB_MAG,   ND_MAG, C_MUL,  STEP_FIRST};
			4'd4:  w = ctrl_t'{ACT_SQ,   SA_K,   SB_K,     ND_ONE, C_NEXT, STEP_FIRST};
			4'd5:  w = ctrl_t'{ACT_MAC,  SA_VAR, SB_K2,    ND_TWO, C_MUL,  STEP_FIRST};
			4'd6:  w = ctrl_t'{ACT_TEST, SA_K,   SB_K,     ND_ONE, C_NEXT, STEP_FIRST};
			4'd7:  w = ctrl_t'{ACT_MAC,  SA_MAG, SB_ALPHA, ND_ONE, C_MUL,  STEP_FIRST};
			4'd8:  w = ctrl_t'{ACT_INCR, SA_K,   SB_K,     ND_ONE, C_NEXT, STEP_FIRST};
			4'd9:  w = ctrl_t'{ACT_MEAN, SA_K,   SB_K,     ND_ONE, C_NEXT, STEP_FIRST};
			4'd10: w = ctrl_t'{ACT_MAC,  SA_MAG, SB_INCR,  ND_MAG, C_MUL,  STEP_FIRST};
			4'd11: w = ctrl_t'{ACT_T,    SA_K,   SB_K,     ND_ONE, C_NEXT, STEP_FIRST};
			4'd12: w = ctrl_t'{ACT_SUM,  SA_K,   SB_K,     ND_ONE, C_NEXT, STEP_FIRST};
			4'd13: w = ctrl_t'{ACT_MAC,  SA_VAR, SB_OMA,   ND_TWO, C_MUL,  STEP_FIRST};
			4'd14: w = ctrl_t'{ACT_VAR,  SA_K,   SB_K,     ND_ONE, C_NEXT, STEP_FIRST};
			4'd15: w = ctrl_t'{ACT_FIN,  SA_K,   SB_K,     ND_ONE, C_OUT,  STEP_FIRST};
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/ewma_ad_if.sv =====
// ewma_ad_if: valid/ready stream interfaces for the sample input and the
// anomaly result of the EWMA anomaly detector. No dependencies.
interface ewma_ad_sample_if #(parameter int SAMPLE_WIDTH = 16) ();
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface ewma_ad_result_if ();
	logic valid;
	logic ready;
	logic anomaly;

	modport source (output valid, output anomaly, input ready);
	modport sink   (input valid, input anomaly, output ready);
endinterface

// ===== rtl/ewma_anomaly_detector_top.sv =====
// ewma_anomaly_detector_top: microcoded EWMA control-chart anomaly detector.
// Depends on ewma_ad_pkg (control word, program ROM) and ewma_ad_if (streams).

// One signed sample beat in, one anomaly beat out. The block holds a sample
// count, an EWMA mean (signed Q(SAMPLE_WIDTH).16) and a saturating EWMA variance
// (unsigned Q32.16); the first sample seeds the mean. A 16-step program in a ROM
// drives one shared multiplier that takes a 16-bit digit of its second operand
// per cycle; the seeding first sample jumps from the first step straight to the
// last. Six products are formed one after another on that multiplier; a new
// sample is taken once the program has handed its result to the output register,
// even while that result still waits for the sink. Registers: alpha_q16 at 0x0,
// k_q8 at 0x4, warmup_count at 0x8. The user must write them only while the block
// is idle; the block itself does not enforce this.
module ewma_anomaly_detector_top #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	ewma_ad_sample_if.sink   in_ch,
	ewma_ad_result_if.source out_ch
);

	localparam int VAR_W = ewma_ad_pkg::VAR_W;
	localparam int DB    = ewma_ad_pkg::DIG_BITS;
	localparam int MW    = SAMPLE_WIDTH + 16;
	localparam int MAGW  = MW;
	localparam int NDM   = (MAGW + DB - 1) / DB;
	localparam int NDMAX = (NDM > 2) ? NDM : 2;
	localparam int DIGW  = $clog2(NDMAX);
	localparam int BW    = DB * NDMAX;
	localparam int AW    = (MAGW > VAR_W) ? MAGW : VAR_W;
	localparam int ACCW  = AW + BW;
	localparam int SQW   = 2 * MAGW;
	localparam int HIW   = ACCW - DB;

	localparam logic signed [MW+1:0] MEAN_MAX = {3'b000, {(MW-1){1'b1}}};
	localparam logic signed [MW+1:0] MEAN_MIN = {3'b111, {(MW-1){1'b0}}};

	// configuration registers
	logic [ewma_ad_pkg::REG_W-1:0] alpha_q;
	logic [ewma_ad_pkg::REG_W-1:0] k_q;
	logic [ewma_ad_pkg::REG_W-1:0] warm_q;

	// sequencer
	logic                busy_q;
	ewma_ad_pkg::step_t  step_q;
	logic [DIGW-1:0]     dig_q;
	logic                res_valid_q;
	logic                res_anom_q;

	// algorithm state
	logic [ewma_ad_pkg::COUNT_W-1:0] count_q;
	logic signed [MW-1:0]            mean_q;
	logic [VAR_W-1:0]                var_q;

	// working registers
	logic signed [SAMPLE_WIDTH-1:0] x_q;
	logic [MAGW-1:0]                mag_q;
	logic                           neg_q;
	logic                           test_q;
	logic                           anom_q;
	logic [ACCW-1:0]                acc_q;
	logic [31:0]                    k2_q;
	logic [SQW-1:0]                 sq_q;
	logic [MAGW-1:0]                incr_q;
	logic [VAR_W-1:0]               t_q;

	// combinational
	ewma_ad_pkg::ctrl_t  word;
	ewma_ad_pkg::ctrl_t  nxt_word;
	ewma_ad_pkg::step_t  step_nxt;
	logic                adv;
	logic                out_free;
	logic                first_w;
	logic                seed_w;
	logic                test_w;
	logic [ewma_ad_pkg::COUNT_W-1:0] cnt_nxt;
	logic signed [MW-1:0]            xq_w;
	logic signed [MW:0]              d_w;
	logic [MAGW-1:0]                 mag_w;
	logic [AW-1:0]                   a_val;
	logic [BW-1:0]                   b_val;
	logic [DB-1:0]                   digit;
	logic [AW+DB-1:0]                prod_w;
	logic [ACCW-1:0]                 acc_nxt;
	logic [ACCW-1:0]                 rnd_w;
	logic [HIW-1:0]                  hi_w;
	logic [VAR_W-1:0]                t_w;
	logic [VAR_W:0]                  s_w;
	logic [VAR_W-1:0]                s_sat;
	logic [16:0]                     oma_w;
	logic signed [MW+1:0]            m_ext;
	logic signed [MW+1:0]            i_ext;
	logic signed [MW+1:0]            m_sum;
	logic signed [MW+1:0]            m_clamp;

	// index of the most significant digit for a digit-count code
	function automatic logic [DIGW-1:0] top_digit(input ewma_ad_pkg::nd_t nd);
		logic [DIGW-1:0] r;
		unique case (nd)
			ewma_ad_pkg::ND_ONE: r = '0;
			ewma_ad_pkg::ND_TWO: r = DIGW'(1);
			ewma_ad_pkg::ND_MAG: r = DIGW'(NDM - 1);
			default:             r = '0;
		endcase
		return r;
	endfunction

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ewma_ad_pkg::ALPHA_RESET;
			k_q     <= ewma_ad_pkg::K_RESET;
			warm_q  <= ewma_ad_pkg::WARMUP_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[3:2])
				ewma_ad_pkg::REG_ALPHA:  alpha_q <= pwdata[15:0];
				ewma_ad_pkg::REG_K:      k_q     <= pwdata[15:0];
				ewma_ad_pkg::REG_WARMUP: warm_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			ewma_ad_pkg::REG_ALPHA:  prdata = 32'(alpha_q);
			ewma_ad_pkg::REG_K:      prdata = 32'(k_q);
			ewma_ad_pkg::REG_WARMUP: prdata = 32'(warm_q);
			default:                 prdata = '0;
		endcase
	end

	// stream handshakes
	assign in_ch.ready    = !busy_q;
	assign out_ch.valid   = res_valid_q;
	assign out_ch.anomaly = res_anom_q;
	assign out_free       = !res_valid_q || out_ch.ready;

	// sample prep: count update, deviation and its magnitude
	assign cnt_nxt = ((count_q < 17'd2) || (count_q <= 17'(warm_q))) ?
		count_q + 17'd1 : count_q;
	assign seed_w  = (cnt_nxt == 17'd1);
	assign test_w  = (cnt_nxt > 17'(warm_q)) && (var_q != '0);
	assign xq_w    = {x_q, 16'h0000};
	assign d_w     = {xq_w[MW-1], xq_w} - {mean_q[MW-1], mean_q};
	assign mag_w   = d_w[MW] ? MAGW'(-d_w) : d_w[MAGW-1:0];

	// shared multiplier, msb digit first
	assign oma_w = 17'h10000 - {1'b0, alpha_q};

	always_comb begin
		unique case (word.sel_a)
			ewma_ad_pkg::SA_K:   a_val = AW'(k_q);
			ewma_ad_pkg::SA_MAG: a_val = AW'(mag_q);
			ewma_ad_pkg::SA_VAR: a_val = AW'(var_q);
			default:             a_val = '0;
		endcase
		unique case (word.sel_b)
			ewma_ad_pkg::SB_K:     b_val = BW'(k_q);
			ewma_ad_pkg::SB_MAG:   b_val = BW'(mag_q);
			ewma_ad_pkg::SB_K2:    b_val = BW'(k2_q);
			ewma_ad_pkg::SB_ALPHA: b_val = BW'(alpha_q);
			ewma_ad_pkg::SB_INCR:  b_val = BW'(incr_q);
			ewma_ad_pkg::SB_OMA:   b_val = BW'(oma_w);
			default:               b_val = '0;
		endcase
	end

	assign digit   = b_val[dig_q*DB +: DB];
	assign prod_w  = a_val * digit;
	assign first_w = (dig_q == top_digit(word.nd));
	assign acc_nxt = (first_w ? '0 : (acc_q << DB)) + ACCW'(prod_w);

	// rounding of products
	assign rnd_w = acc_q + ACCW'(32'h8000);
	assign hi_w  = acc_q[ACCW-1:DB] + HIW'(acc_q[DB-1]);
	assign t_w   = (hi_w > HIW'(ewma_ad_pkg::VAR_MAX)) ? ewma_ad_pkg::VAR_MAX :
		hi_w[VAR_W-1:0];
	assign s_w   = {1'b0, var_q} + {1'b0, t_q};
	assign s_sat = s_w[VAR_W] ? ewma_ad_pkg::VAR_MAX : s_w[VAR_W-1:0];

	// mean step with clamp to the sample range
	always_comb begin
		m_ext = {{2{mean_q[MW-1]}}, mean_q};
		i_ext = {2'b00, incr_q};
		m_sum = neg_q ? (m_ext - i_ext) : (m_ext + i_ext);
		priority if (m_sum > MEAN_MAX)
			m_clamp = MEAN_MAX;
		else if (m_sum < MEAN_MIN)
			m_clamp = MEAN_MIN;
		else
			m_clamp = m_sum;
	end

	// microcode fetch and next step
	assign word     = ewma_ad_pkg::ctrl_word(step_q);
	assign nxt_word = ewma_ad_pkg::ctrl_word(step_nxt);

	always_comb begin
		step_nxt = step_q + 4'd1;
		adv      = 1'b1;
		unique case (word.cond)
			ewma_ad_pkg::C_NEXT: adv = 1'b1;
			ewma_ad_pkg::C_SEED: begin
				if (seed_w)
					step_nxt = word.target;
			end
			ewma_ad_pkg::C_MUL:  adv = (dig_q == '0);
			ewma_ad_pkg::C_OUT: begin
				adv      = out_free;
				step_nxt = ewma_ad_pkg::STEP_FIRST;
			end
			default: adv = 1'b1;
		endcase
	end

	// sequencer control and output beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= ewma_ad_pkg::STEP_FIRST;
			dig_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (!busy_q) begin
				// idle always sits on the first step
				if (in_ch.valid) begin
					busy_q <= 1'b1;
					step_q <= ewma_ad_pkg::STEP_FIRST;
					dig_q  <= top_digit(word.nd);
				end
			end else if (adv) begin
				step_q <= step_nxt;
				dig_q  <= top_digit(nxt_word.nd);
				if (word.cond == ewma_ad_pkg::C_OUT)
					busy_q <= 1'b0;
			end else if (word.act == ewma_ad_pkg::ACT_MAC) begin
				dig_q <= DIGW'(dig_q - 1'b1);
			end

			if (busy_q && (word.act == ewma_ad_pkg::ACT_FIN) && out_free)
				res_valid_q <= 1'b1;
			else if (out_ch.ready)
				res_valid_q <= 1'b0;
		end
	end

	// count, mean and variance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			mean_q  <= '0;
			var_q   <= '0;
		end else if (busy_q) begin
			unique case (word.act)
				ewma_ad_pkg::ACT_PREP: begin
					count_q <= cnt_nxt;
					if (seed_w) begin
						mean_q <= xq_w;
						var_q  <= '0;
					end
				end
				ewma_ad_pkg::ACT_MEAN: mean_q <= m_clamp[MW-1:0];
				ewma_ad_pkg::ACT_SUM:  var_q  <= s_sat;
				ewma_ad_pkg::ACT_VAR:  var_q  <= rnd_w[DB +: VAR_W];
				default: ;
			endcase
		end
	end

	// working registers of the datapath
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready)
			x_q <= in_ch.sample;
		if (busy_q) begin
			unique case (word.act)
				ewma_ad_pkg::ACT_PREP: begin
					mag_q  <= mag_w;
					neg_q  <= d_w[MW];
					test_q <= test_w;
					anom_q <= 1'b0;
				end
				ewma_ad_pkg::ACT_MAC:  acc_q  <= acc_nxt;
				ewma_ad_pkg::ACT_K2:   k2_q   <= acc_q[31:0];
				ewma_ad_pkg::ACT_SQ:   sq_q   <= acc_q[SQW-1:0];
				ewma_ad_pkg::ACT_TEST: anom_q <= test_q && (ACCW'(sq_q) > acc_q);
				ewma_ad_pkg::ACT_INCR: incr_q <= rnd_w[DB +: MAGW];
				ewma_ad_pkg::ACT_T:    t_q    <= t_w;
				ewma_ad_pkg::ACT_FIN: begin
					if (out_free)
						res_anom_q <= anom_q;
				end
				default: ;
			endcase
		end
	end

endmodule

// ===== dv/ewma_ad_checker.sv =====
`timescale 1ns / 1ps
// ewma_ad_checker: watches the config port and both streams of the EWMA anomaly
// detector, predicts each anomaly flag and compares it. Depends on ewma_ad_pkg.
module ewma_ad_checker #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic                    pready,
	input  logic [3:0]              paddr,
	input  logic [31:0]             pwdata,
	input  logic                    in_valid,
	input  logic                    in_ready,
	input  logic [SAMPLE_WIDTH-1:0] in_sample,
	input  logic                    out_valid,
	input  logic                    out_ready,
	input  logic                    out_anomaly,
	output int                      fail_count,
	output int                      outstanding,
	output int                      checked_count,
	output int                      flagged_count
);

	typedef struct {
		logic                           flag;
		logic signed [SAMPLE_WIDTH-1:0] smp;
		int unsigned                    seq;
	} flag_entry_t;

	// shadow registers and detector state
	logic [ewma_ad_pkg::REG_W-1:0]   alpha_r;
	logic [ewma_ad_pkg::REG_W-1:0]   k_r;
	logic [ewma_ad_pkg::REG_W-1:0]   warm_r;
	logic [ewma_ad_pkg::COUNT_W-1:0] seen_count;
	longint                          ewma_mean;
	logic [ewma_ad_pkg::VAR_W-1:0]   ewma_var;

	flag_entry_t pending_flags[$];
	int unsigned sample_seq;

	task automatic report(input string what);
		fail_count++;
		$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	// test the sample against the baseline, then update mean and variance
	task automatic score_sample(input logic signed [SAMPLE_WIDTH-1:0] smp, output logic flag);
		longint       xq, d, mean_max, mean_min, nmean;
		logic [63:0]  mag, incr;
		logic [127:0] dsq, kvar, prod, t_full, vsum;
		logic [ewma_ad_pkg::VAR_W-1:0] t_sat, s_sat;
		flag = 1'b0;
		xq = longint'(smp) * 65536;
		mean_max = (longint'(1) <<< (SAMPLE_WIDTH + 15)) - 1;
		mean_min = -mean_max - 1;
		if (seen_count < 2 || seen_count <= {1'b0, warm_r})
			seen_count = seen_count + 1'b1;
		if (seen_count == 1) begin
			// first sample seeds the baseline
			ewma_mean = xq;
			ewma_var = '0;
		end else begin
			d = xq - ewma_mean;
			mag = (d < 0) ? 64'(-d) : 64'(d);
			if (seen_count > {1'b0, warm_r} && ewma_var != 0) begin
				dsq = 128'(mag) * 128'(mag);
				kvar = 128'(k_r) * 128'(k_r) * 128'(ewma_var);
				flag = (dsq > kvar);
			end
			// mean step, rounded half away from zero on the magnitude
			incr = (64'(alpha_r) * mag + 64'd32768) >> 16;
			nmean = (d < 0) ? ewma_mean - longint'(incr) : ewma_mean + longint'(incr);
			if (nmean > mean_max)
				nmean = mean_max;
			if (nmean < mean_min)
				nmean = mean_min;
			ewma_mean = nmean;
			// variance step, saturating at every stage
			prod = 128'(mag) * 128'(incr);
			t_full = (prod + 128'd32768) >> 16;
			t_sat = (t_full > 128'(ewma_ad_pkg::VAR_MAX)) ? ewma_ad_pkg::VAR_MAX :
				t_full[ewma_ad_pkg::VAR_W-1:0];
			vsum = 128'(ewma_var) + 128'(t_sat);
			s_sat = (vsum > 128'(ewma_ad_pkg::VAR_MAX)) ? ewma_ad_pkg::VAR_MAX :
				vsum[ewma_ad_pkg::VAR_W-1:0];
			vsum = (128'(s_sat) * 128'(17'd65536 - 17'(alpha_r)) + 128'd32768) >> 16;
			ewma_var = vsum[ewma_ad_pkg::VAR_W-1:0];
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		flag_entry_t e;
		logic        f;
		if (!arst_n) begin
			alpha_r = ewma_ad_pkg::ALPHA_RESET;
			k_r = ewma_ad_pkg::K_RESET;
			warm_r = ewma_ad_pkg::WARMUP_RESET;
			seen_count = '0;
			ewma_mean = 0;
			ewma_var = '0;
			pending_flags.delete();
			sample_seq = 0;
			fail_count = 0;
			checked_count = 0;
			flagged_count = 0;
			outstanding <= 0;
		end else begin
			// register writes land on the access cycle
			if (psel && penable && pwrite && pready) begin
				case (ewma_ad_pkg::reg_idx_t'(paddr[3:2]))
					ewma_ad_pkg::REG_ALPHA:  alpha_r = pwdata[ewma_ad_pkg::REG_W-1:0];
					ewma_ad_pkg::REG_K:      k_r = pwdata[ewma_ad_pkg::REG_W-1:0];
					ewma_ad_pkg::REG_WARMUP: warm_r = pwdata[ewma_ad_pkg::REG_W-1:0];
					default:    ;
				endcase
			end
			// sample beat: predict its flag
			if (in_valid && in_ready) begin
				score_sample($signed(in_sample), f);
				e.flag = f;
				e.smp = $signed(in_sample);
				e.seq = sample_seq;
				sample_seq++;
				pending_flags = {pending_flags, e};
			end
			// result beat: compare with the oldest prediction
			if (out_valid && out_ready) begin
				if (pending_flags.size() == 0) begin
					report("result beat with no sample waiting");
				end else begin
					e = pending_flags.pop_front();
					checked_count++;
					if (out_anomaly === 1'b1)
						flagged_count++;
					if (out_anomaly !== e.flag)
						report($sformatf("sample #%0d (%0d): anomaly %b, wanted %b",
							e.seq, e.smp, out_anomaly, e.flag));
				end
			end
			outstanding <= pending_flags.size();
		end
	end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for ewma_anomaly_detector_top; drives the config
// port and sample stream, throttles the result stream. Needs ewma_ad_pkg, ewma_ad_if.
module tb_top;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int fail_count;
	int outstanding;
	int checked_count;
	int flagged_count;

	// shared with the result-side process
	bit quiet = 1'b0;
	int hold_request = 0;
	int hold_left = 0;

	int unsigned sent_count = 0;
	int unsigned settings_count = 0;

	// segment state of the random sample source
	int seg_base = 0;
	int seg_spread = 1;
	int seg_left = 0;

	// seed, extremes, flat run, then a spike past warmup
	int dir_reset [14] = '{-32768, 32767, -32768, 0, -1, 1, 100, 100, 100, 100, 100, 100,
		32767, -32768};
	// full alpha swings drive the variance sum into saturation, zero k flags any nonzero deviation
	int dir_sat [6] = '{32767, -32768, 32767, -32768, 5, 5};
	// zero alpha freezes the baseline
	int dir_frozen [4] = '{1000, -1000, 0, 1000};

	ewma_ad_sample_if #(.SAMPLE_WIDTH(16)) smp_if ();
	ewma_ad_result_if res_if ();

	ewma_anomaly_detector_top #(.SAMPLE_WIDTH(16)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.in_ch   (smp_if),
		.out_ch  (res_if)
	);

	ewma_ad_checker #(.SAMPLE_WIDTH(16)) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.pready        (pready),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.in_valid      (smp_if.valid),
		.in_ready      (smp_if.ready),
		.in_sample     (smp_if.sample),
		.out_valid     (res_if.valid),
		.out_ready     (res_if.ready),
		.out_anomaly   (res_if.anomaly),
		.fail_count    (fail_count),
		.outstanding   (outstanding),
		.checked_count (checked_count),
		.flagged_count (flagged_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hard stop
	initial begin
		#(5_000_000);
		$display("timeout: results still outstanding");
		$display("CHECK FAILED");
		$finish;
	end

	// result side: random stalls, long hold-offs on request
	initial begin
		res_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				res_if.ready <= 1'b0;
			end else if (quiet) begin
				res_if.ready <= 1'b1;
			end else begin
				res_if.ready <= ($urandom_range(0, 99) >= 6);
			end
		end
	end

	// one sample beat, with an occasional gap in front of it
	task automatic push_sample(input logic signed [15:0] v);
		if (!quiet && $urandom_range(0, 99) < 6) begin
			smp_if.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		smp_if.valid <= 1'b1;
		smp_if.sample <= v;
		sent_count++;
		@(posedge clk);
		while (!smp_if.ready) @(posedge clk);
	endtask

	// apb write, setup then access; psel is left high for back-to-back writes
	task automatic reg_write(input ewma_ad_pkg::reg_idx_t idx,
		input logic [ewma_ad_pkg::REG_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= 32'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
	endtask

	// drain every result, then rewrite all three registers
	task automatic apply_settings(input logic [ewma_ad_pkg::REG_W-1:0] a,
		input logic [ewma_ad_pkg::REG_W-1:0] k, input logic [ewma_ad_pkg::REG_W-1:0] w);
		smp_if.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		reg_write(ewma_ad_pkg::REG_ALPHA, a);
		reg_write(ewma_ad_pkg::REG_K, k);
		reg_write(ewma_ad_pkg::REG_WARMUP, w);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		settings_count++;
	endtask

	// baseline plus noise in segments, with spikes and full-range values mixed in
	task automatic pick_sample(output logic signed [15:0] v);
		int val;
		int r;
		if (seg_left == 0) begin
			seg_base = int'($urandom_range(0, 65535)) - 32768;
			seg_spread = 1 << $urandom_range(0, 11);
			seg_left = int'($urandom_range(20, 80));
		end
		seg_left--;
		r = int'($urandom_range(0, 99));
		if (r < 5)
			val = int'($urandom_range(0, 65535)) - 32768;
		else if (r < 10)
			val = seg_base + ($urandom_range(0, 1) ? 1 : -1) * seg_spread *
				int'($urandom_range(4, 40));
		else
			val = seg_base + int'($urandom_range(0, 2 * seg_spread)) - seg_spread;
		if (val > 32767)
			val = 32767;
		if (val < -32768)
			val = -32768;
		v = 16'(val);
	endtask

	initial begin
		logic signed [15:0]            smp_val;
		logic [ewma_ad_pkg::REG_W-1:0] a;
		logic [ewma_ad_pkg::REG_W-1:0] k;
		logic [ewma_ad_pkg::REG_W-1:0] w;
		int                            len;
		smp_if.valid <= 1'b0;
		smp_if.sample <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings first, then the saturating and frozen corners
		foreach (dir_reset[i]) push_sample(16'(dir_reset[i]));
		apply_settings(16'd65535, 16'd0, 16'd0);
		foreach (dir_sat[i]) push_sample(16'(dir_sat[i]));
		apply_settings(16'd0, 16'd65535, 16'd65535);
		foreach (dir_frozen[i]) push_sample(16'(dir_frozen[i]));

		// random phases, each under its own settings
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin
					a = ewma_ad_pkg::ALPHA_RESET;
					k = ewma_ad_pkg::K_RESET;
					w = ewma_ad_pkg::WARMUP_RESET;
					len = 300;
				end
				1: begin a = 16'd1; k = 16'd256; w = 16'd3; len = 200; end
				2: begin a = 16'd65535; k = 16'd65535; w = 16'd0; len = 150; end
				3: begin a = 16'd32768; k = 16'd0; w = 16'd65535; len = 150; end
				default: begin
					a = 16'($urandom_range(1, 65535));
					k = 16'($urandom_range(0, 1200));
					w = 16'($urandom_range(0, 40));
					len = 180;
				end
			endcase
			apply_settings(a, k, w);
			quiet = (ph == 1);
			for (int n = 0; n < len; n++) begin
				// long result hold-off while samples keep coming
				if (ph == 0 && n == 120)
					hold_request = 400;
				pick_sample(smp_val);
				push_sample(smp_val);
			end
		end
		quiet = 1'b0;

		smp_if.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (40) @(posedge clk);

		$display("sent %0d samples under %0d register settings plus reset values",
			sent_count, settings_count);
		$display("checked %0d anomaly results, %0d of them flagged", checked_count,
			flagged_count);
		if (fail_count == 0 && outstanding == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
